/* rtl/core/lsovt_pkg.sv */
// shared types and constants of the load/store ordering violation tracker
`default_nettype none
package lsovt_pkg;

  localparam int unsigned LOAD_RING_DEPTH  = 16;
  localparam int unsigned STORE_RING_DEPTH = 16;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STORE   = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_CONSUME = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_e;

  // one ring entry as it moves from cell to cell
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // control broadcast to every cell of a row
  typedef struct packed {
    logic shift;
    logic cmp;
  } cell_ctrl_t;

  // exclusive end of a byte range, wrapping, zero length counts as one
  function automatic logic [ADDR_W-1:0] range_end(input logic [ADDR_W-1:0] a,
                                                  input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] len;
    len = (sz == '0) ? SIZE_W'(1) : sz;
    return a + ADDR_W'(len);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/lsovt_cell.sv */
// one ring cell: holds an entry, shifts it on, compares it with the request
`default_nettype none
module lsovt_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lsovt_pkg::cell_ctrl_t         ctrl_i,
  input  wire lsovt_pkg::entry_t             entry_i,
  input  wire logic [lsovt_pkg::ADDR_W-1:0]  req_addr_i,
  input  wire logic [lsovt_pkg::ADDR_W-1:0]  req_end_i,
  input  wire logic                          hit_i,
  output lsovt_pkg::entry_t                  entry_o,
  output logic                               hit_o
);

  logic                         valid_q;
  logic [lsovt_pkg::ADDR_W-1:0] addr_q;
  logic [lsovt_pkg::SIZE_W-1:0] size_q;
  logic                         match_q;
  logic                         match_d;
  logic [lsovt_pkg::ADDR_W-1:0] own_end;

  assign own_end = lsovt_pkg::range_end(addr_q, size_q);
  assign match_d = valid_q && (req_addr_i < own_end) && (addr_q < req_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.shift) begin
        valid_q <= entry_i.valid;
      end
      if (ctrl_i.cmp) begin
        match_q <= match_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      addr_q <= entry_i.addr;
      size_q <= entry_i.size;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.addr  = addr_q;
  assign entry_o.size  = size_q;
  assign hit_o         = hit_i | match_q;

endmodule
`default_nettype wire

/* rtl/core/load_store_ordering_violation_tracker_unit.sv */
// top level: two rows of ring cells, command sequencer, replay slot and event counters
`default_nettype none
// A command is accepted when start is high and busy is low. The idle state
// takes the transfer; in the compare state every cell of the load row or
// the store row compares its entry with the access and registers the match,
// and in the update state the matches are gathered along the row, the rows
// shift on a push, the counters and the replay slot are updated and the
// result is written. done_o is high for the single cycle that follows, in
// which the result ports and the counters are valid; busy is low in that
// cycle, so the next command may be taken there. The receiver cannot stall:
// it must take the result in the cycle that done_o marks. A push shifts the
// row by one cell; an entry falling off the far end of a full row counts as
// a drop.
module load_store_ordering_violation_tracker_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command_i,
  input  wire logic [lsovt_pkg::ADDR_W-1:0]  address_i,
  input  wire logic [lsovt_pkg::SIZE_W-1:0]  access_size_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic [lsovt_pkg::SEQ_W-1:0]        replay_seq_o,
  output logic [lsovt_pkg::ADDR_W-1:0]       replay_address_o,
  output logic [lsovt_pkg::SIZE_W-1:0]       replay_size_o,
  output logic [lsovt_pkg::CNT_W-1:0]        reorder_count_o,
  output logic [lsovt_pkg::CNT_W-1:0]        violation_count_o,
  output logic [lsovt_pkg::CNT_W-1:0]        drop_count_o,
  output logic [lsovt_pkg::CNT_W-1:0]        load_count_o,
  output logic [lsovt_pkg::CNT_W-1:0]        store_count_o,
  output logic [lsovt_pkg::CNT_W-1:0]        consumed_count_o
);

  localparam int unsigned LD = lsovt_pkg::LOAD_RING_DEPTH;
  localparam int unsigned SD = lsovt_pkg::STORE_RING_DEPTH;

  lsovt_pkg::state_e state_q, state_d;
  logic cmp_en, upd_en, accept;

  lsovt_pkg::cmd_e              req_cmd_q;
  logic [lsovt_pkg::ADDR_W-1:0] req_addr_q;
  logic [lsovt_pkg::SIZE_W-1:0] req_size_q;
  logic [lsovt_pkg::ADDR_W-1:0] req_end_q;

  lsovt_pkg::entry_t     req_entry;
  lsovt_pkg::cell_ctrl_t ld_ctrl, st_ctrl;
  lsovt_pkg::entry_t     ld_chain [LD+1];
  lsovt_pkg::entry_t     st_chain [SD+1];
  logic [LD:0]           ld_hit;
  logic [SD:0]           st_hit;

  logic                         done_q;
  logic                         hit_q;
  logic [lsovt_pkg::SEQ_W-1:0]  out_seq_q;
  logic [lsovt_pkg::ADDR_W-1:0] out_addr_q;
  logic [lsovt_pkg::SIZE_W-1:0] out_size_q;

  logic [lsovt_pkg::SEQ_W-1:0]  next_seq_q;
  logic                         rp_valid_q;
  logic [lsovt_pkg::SEQ_W-1:0]  rp_seq_q;
  logic [lsovt_pkg::ADDR_W-1:0] rp_addr_q;
  logic [lsovt_pkg::SIZE_W-1:0] rp_size_q;

  logic [lsovt_pkg::CNT_W-1:0] reorder_q, violation_q, drop_q, load_q, store_q, consumed_q;

  logic is_load, is_store, is_check, is_consume, ld_hit_any, st_hit_any, drop;

  assign accept = start && !busy;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsovt_pkg::ST_IDLE:    if (start) state_d = lsovt_pkg::ST_COMPARE;
      lsovt_pkg::ST_COMPARE: state_d = lsovt_pkg::ST_UPDATE;
      lsovt_pkg::ST_UPDATE:  state_d = lsovt_pkg::ST_IDLE;
      default:               state_d = lsovt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_q != lsovt_pkg::ST_IDLE);
    cmp_en = (state_q == lsovt_pkg::ST_COMPARE);
    upd_en = (state_q == lsovt_pkg::ST_UPDATE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsovt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_cmd_q  <= lsovt_pkg::cmd_e'(command_i);
      req_addr_q <= address_i;
      req_size_q <= access_size_i;
      req_end_q  <= lsovt_pkg::range_end(address_i, access_size_i);
    end
  end

  assign is_load    = (req_cmd_q == lsovt_pkg::CMD_LOAD);
  assign is_store   = (req_cmd_q == lsovt_pkg::CMD_STORE);
  assign is_check   = (req_cmd_q == lsovt_pkg::CMD_CHECK);
  assign is_consume = (req_cmd_q == lsovt_pkg::CMD_CONSUME);

  assign req_entry.valid = 1'b1;
  assign req_entry.addr  = req_addr_q;
  assign req_entry.size  = req_size_q;

  assign ld_ctrl.cmp   = cmp_en && is_load;
  assign ld_ctrl.shift = upd_en && is_load;
  assign st_ctrl.cmp   = cmp_en && is_check;
  assign st_ctrl.shift = upd_en && is_store;

  assign ld_chain[0] = req_entry;
  assign st_chain[0] = req_entry;
  assign ld_hit[0]   = 1'b0;
  assign st_hit[0]   = 1'b0;

  for (genvar i = 0; i < LD; i++) begin : g_ld
    lsovt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ld_ctrl),
      .entry_i    (ld_chain[i]),
      .req_addr_i (req_addr_q),
      .req_end_i  (req_end_q),
      .hit_i      (ld_hit[i]),
      .entry_o    (ld_chain[i+1]),
      .hit_o      (ld_hit[i+1])
    );
  end

  for (genvar i = 0; i < SD; i++) begin : g_st
    lsovt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (st_ctrl),
      .entry_i    (st_chain[i]),
      .req_addr_i (req_addr_q),
      .req_end_i  (req_end_q),
      .hit_i      (st_hit[i]),
      .entry_o    (st_chain[i+1]),
      .hit_o      (st_hit[i+1])
    );
  end

  assign ld_hit_any = ld_hit[LD];
  assign st_hit_any = st_hit[SD];
  // last cell valid means the row is full
  assign drop = (is_load && ld_chain[LD].valid) || (is_store && st_chain[SD].valid);

  // update, replay slot and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_seq_q   <= '0;
      out_addr_q  <= '0;
      out_size_q  <= '0;
      next_seq_q  <= lsovt_pkg::SEQ_W'(1);
      rp_valid_q  <= 1'b0;
      rp_seq_q    <= '0;
      rp_addr_q   <= '0;
      rp_size_q   <= '0;
      reorder_q   <= '0;
      violation_q <= '0;
      drop_q      <= '0;
      load_q      <= '0;
      store_q     <= '0;
      consumed_q  <= '0;
    end else begin
      done_q <= upd_en;
      if (upd_en) begin
        hit_q      <= 1'b0;
        out_seq_q  <= '0;
        out_addr_q <= '0;
        out_size_q <= '0;
        drop_q     <= drop_q + lsovt_pkg::CNT_W'(drop);
        unique case (req_cmd_q)
          lsovt_pkg::CMD_LOAD: begin
            hit_q      <= ld_hit_any;
            next_seq_q <= next_seq_q + lsovt_pkg::SEQ_W'(1);
            reorder_q  <= reorder_q + lsovt_pkg::CNT_W'(ld_hit_any);
            load_q     <= load_q + lsovt_pkg::CNT_W'(1);
          end
          lsovt_pkg::CMD_STORE: begin
            next_seq_q <= next_seq_q + lsovt_pkg::SEQ_W'(1);
            store_q    <= store_q + lsovt_pkg::CNT_W'(1);
          end
          lsovt_pkg::CMD_CHECK: begin
            hit_q <= st_hit_any;
            if (st_hit_any) begin
              violation_q <= violation_q + lsovt_pkg::CNT_W'(1);
              rp_valid_q  <= 1'b1;
              rp_seq_q    <= next_seq_q;
              rp_addr_q   <= req_addr_q;
              rp_size_q   <= req_size_q;
              next_seq_q  <= next_seq_q + lsovt_pkg::SEQ_W'(1);
            end
          end
          lsovt_pkg::CMD_CONSUME: begin
            hit_q <= rp_valid_q;
            if (rp_valid_q) begin
              out_seq_q  <= rp_seq_q;
              out_addr_q <= rp_addr_q;
              out_size_q <= rp_size_q;
              rp_valid_q <= 1'b0;
              rp_seq_q   <= '0;
              rp_addr_q  <= '0;
              rp_size_q  <= '0;
              consumed_q <= consumed_q + lsovt_pkg::CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign replay_seq_o      = out_seq_q;
  assign replay_address_o  = out_addr_q;
  assign replay_size_o     = out_size_q;
  assign reorder_count_o   = reorder_q;
  assign violation_count_o = violation_q;
  assign drop_count_o      = drop_q;
  assign load_count_o      = load_q;
  assign store_count_o     = store_q;
  assign consumed_count_o  = consumed_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("transfer did not give a result three cycles later");

  a_store_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && is_store) |=> store_q == $past(store_q) + lsovt_pkg::CNT_W'(1))
    else $error("store count not advanced");

  a_consume_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && is_consume) |=> !rp_valid_q)
    else $error("replay slot still pending after consume");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the load/store ordering violation tracker
`default_nettype none
module tb_top;
  import lsovt_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } access_t;

  typedef struct packed {
    logic              hit;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  reorders;
    logic [CNT_W-1:0]  violations;
    logic [CNT_W-1:0]  drops;
    logic [CNT_W-1:0]  loads;
    logic [CNT_W-1:0]  stores;
    logic [CNT_W-1:0]  consumed;
  } outcome_t;

  class ordering_scoreboard;
    access_t           load_ring[$];
    access_t           store_ring[$];
    bit [SEQ_W-1:0]    next_seq = 1;
    bit                replay_valid;
    bit [SEQ_W-1:0]    replay_seq;
    bit [ADDR_W-1:0]   replay_addr;
    bit [SIZE_W-1:0]   replay_size;
    bit [CNT_W-1:0]    reorders, violations, drops, loads, stores, consumed;
    outcome_t          tracker_outcomes_q[$];
    int unsigned       errors;

    function bit ranges_meet(access_t x, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] sz);
      logic [ADDR_W-1:0] x_end, a_end;
      x_end = x.addr + ADDR_W'((x.size == '0) ? SIZE_W'(1) : x.size);
      a_end = a + ADDR_W'((sz == '0) ? SIZE_W'(1) : sz);
      return (a < x_end) && (x.addr < a_end);
    endfunction

    function bit any_overlap(access_t ring[$], logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] sz);
      foreach (ring[i])
        if (ranges_meet(ring[i], a, sz)) return 1'b1;
      return 1'b0;
    endfunction

    function void push_access(ref access_t ring[$], input int unsigned depth,
                              input access_t acc);
      if (ring.size() >= depth) begin
        void'(ring.pop_front());
        drops++;
      end
      ring.push_back(acc);
    endfunction

    // predicts the outcome of one accepted command
    function void note_command(cmd_e cmd, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] sz);
      outcome_t o;
      bit found;
      o = '0;
      found = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          next_seq++;
          found = any_overlap(load_ring, a, sz);
          if (found) reorders++;
          push_access(load_ring, LOAD_RING_DEPTH, '{addr: a, size: sz});
          loads++;
        end
        CMD_STORE: begin
          next_seq++;
          push_access(store_ring, STORE_RING_DEPTH, '{addr: a, size: sz});
          stores++;
        end
        CMD_CHECK: begin
          found = any_overlap(store_ring, a, sz);
          if (found) begin
            violations++;
            replay_valid = 1'b1;
            replay_seq = next_seq;
            next_seq++;
            replay_addr = a;
            replay_size = sz;
          end
        end
        default: begin
          if (replay_valid) begin
            found = 1'b1;
            o.seq = replay_seq;
            o.addr = replay_addr;
            o.size = replay_size;
            replay_valid = 1'b0;
            consumed++;
          end
        end
      endcase
      o.hit = found;
      o.reorders = reorders;
      o.violations = violations;
      o.drops = drops;
      o.loads = loads;
      o.stores = stores;
      o.consumed = consumed;
      tracker_outcomes_q.push_back(o);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (tracker_outcomes_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer expected none actual %0h", $time, got);
        return;
      end
      want = tracker_outcomes_q.pop_front();
      compare_field("hit", 64'(want.hit), 64'(got.hit));
      compare_field("replay_seq", 64'(want.seq), 64'(got.seq));
      compare_field("replay_address", want.addr, got.addr);
      compare_field("replay_size", 64'(want.size), 64'(got.size));
      compare_field("reorder_count", 64'(want.reorders), 64'(got.reorders));
      compare_field("violation_count", 64'(want.violations), 64'(got.violations));
      compare_field("drop_count", 64'(want.drops), 64'(got.drops));
      compare_field("load_count", 64'(want.loads), 64'(got.loads));
      compare_field("store_count", 64'(want.stores), 64'(got.stores));
      compare_field("consumed_count", 64'(want.consumed), 64'(got.consumed));
    endfunction

    function int unsigned pending();
      return tracker_outcomes_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command_i = CMD_LOAD;
  logic [ADDR_W-1:0] address_i = '0;
  logic [SIZE_W-1:0] access_size_i = '0;
  logic              done_o;
  logic              hit_o;
  logic [SEQ_W-1:0]  replay_seq_o;
  logic [ADDR_W-1:0] replay_address_o;
  logic [SIZE_W-1:0] replay_size_o;
  logic [CNT_W-1:0]  reorder_count_o, violation_count_o, drop_count_o;
  logic [CNT_W-1:0]  load_count_o, store_count_o, consumed_count_o;

  ordering_scoreboard sb;

  load_store_ordering_violation_tracker_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .address_i         (address_i),
    .access_size_i     (access_size_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .replay_seq_o      (replay_seq_o),
    .replay_address_o  (replay_address_o),
    .replay_size_o     (replay_size_o),
    .reorder_count_o   (reorder_count_o),
    .violation_count_o (violation_count_o),
    .drop_count_o      (drop_count_o),
    .load_count_o      (load_count_o),
    .store_count_o     (store_count_o),
    .consumed_count_o  (consumed_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_command(cmd_e'(command_i), address_i, access_size_i);
    if (rst_ni && done_o)
      sb.check_outcome('{hit_o, replay_seq_o, replay_address_o, replay_size_o,
                         reorder_count_o, violation_count_o, drop_count_o,
                         load_count_o, store_count_o, consumed_count_o});
  end

  function automatic int unsigned gap_len(bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // holds the command until busy is low at a clock edge
  task automatic issue(cmd_e cmd, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] sz,
                       bit no_idle = 1'b0);
    int unsigned gap;
    gap = gap_len(no_idle);
    start <= 1'b1;
    command_i <= cmd;
    address_i <= a;
    access_size_i <= sz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    cmd_e              cmd;
    logic [ADDR_W-1:0] base, a;
    logic [SIZE_W-1:0] sz;
    int unsigned       r;
    bit                no_idle;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    issue(CMD_CONSUME, '0, '0);
    issue(CMD_CHECK, '0, '0);
    issue(CMD_LOAD, '0, '0);
    issue(CMD_LOAD, '0, 16'd1);
    issue(CMD_LOAD, 64'd1, '0);
    issue(CMD_STORE, 64'h1000, 16'hFFFF);
    issue(CMD_CHECK, 64'h1000 + 64'hFFFE, '0);
    issue(CMD_CHECK, 64'h1000 + 64'hFFFF, 16'd4);
    issue(CMD_CHECK, 64'hFFF, 16'd1);
    issue(CMD_CHECK, 64'hFFF, 16'd2);
    issue(CMD_CONSUME, '0, '0);
    issue(CMD_CONSUME, '0, '0);
    // range ends wrapping past the top of the address space
    issue(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFF0, 16'h20);
    issue(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFF8, 16'd1);
    issue(CMD_CHECK, '0, '0);
    issue(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    issue(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    issue(CMD_LOAD, 64'h5555_5555_5555_5555, 16'h5555);
    issue(CMD_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
    issue(CMD_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
    issue(CMD_CHECK, 64'hAAAA_AAAA_AAAA_AAAB, 16'd1);
    issue(CMD_CONSUME, '0, '0);
    drain();

    for (int phase = 0; phase < 11; phase++) begin
      base = (phase == 0) ? '0 : ({$urandom, $urandom} & ~64'hFFF);
      no_idle = (phase % 4 == 1);
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        cmd = (r < 30) ? CMD_LOAD : (r < 55) ? CMD_STORE : (r < 85) ? CMD_CHECK : CMD_CONSUME;
        case ($urandom_range(0, 9))
          0: a = {$urandom, $urandom};
          1: a = 64'hFFFF_FFFF_FFFF_FF00 | ADDR_W'($urandom_range(0, 255));
          default: a = base + ADDR_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
          0: sz = SIZE_W'($urandom);
          1: sz = 16'hFFFF;
          2: sz = '0;
          default: sz = SIZE_W'($urandom_range(1, 16));
        endcase
        issue(cmd, a, sz, no_idle);
      end
      drain();
    end

    repeat (6) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
